[sv/bmhq_pkg.sv]
// Shared constants, command and status codes, and the controller/datapath
// interface structs of the binary min-heap queue. No dependencies.
package bmhq_pkg;

   localparam int CAPACITY_DEF     = 2048;
   localparam int NODE_ID_BITS_DEF = 11;
   localparam int KEY_BITS_DEF     = 32;
   localparam int COST_BITS        = 32;

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_POP      = 2'd1;
   localparam logic [1:0] CMD_DECREASE = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   // Datapath operations issued by the controller, one per cycle.
   localparam logic [4:0] OP_IDLE       = 5'd0;
   localparam logic [4:0] OP_LOAD       = 5'd1;
   localparam logic [4:0] OP_INS_START  = 5'd2;
   localparam logic [4:0] OP_POP_START  = 5'd3;
   localparam logic [4:0] OP_SCAN_START = 5'd4;
   localparam logic [4:0] OP_UP_READ    = 5'd5;
   localparam logic [4:0] OP_UP_MOVE    = 5'd6;
   localparam logic [4:0] OP_PLACE      = 5'd7;
   localparam logic [4:0] OP_POP_ROOT   = 5'd8;
   localparam logic [4:0] OP_POP_LAST   = 5'd9;
   localparam logic [4:0] OP_DN_READ    = 5'd10;
   localparam logic [4:0] OP_DN_LEFT    = 5'd11;
   localparam logic [4:0] OP_DN_RIGHT   = 5'd12;
   localparam logic [4:0] OP_DN_MOVE    = 5'd13;
   localparam logic [4:0] OP_SCAN_NEXT  = 5'd14;
   localparam logic [4:0] OP_SCAN_HIT   = 5'd15;
   localparam logic [4:0] OP_RESPOND    = 5'd16;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] status;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       empty;
      logic       idx_zero;
      logic       up_swap;
      logic       dn_leaf;
      logic       right_in;
      logic       cand_item;
      logic       id_match;
      logic       scan_end;
   } dp_stat_type;

endpackage

[sv/bmhq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bmhq_datapath.sv]
// Heap datapath: request and response registers, entry count, sift index,
// moving entry and candidate registers around one heap RAM.
// Depends on bmhq_pkg and bmhq_ram.
module bmhq_datapath #(
   parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
   parameter int NODE_ID_BITS = bmhq_pkg::NODE_ID_BITS_DEF,
   parameter int KEY_BITS     = bmhq_pkg::KEY_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bmhq_pkg::dp_cmd_type                 cmd,
   output bmhq_pkg::dp_stat_type                stat,
   input  logic [1:0]                           req_cmd,
   input  logic [NODE_ID_BITS-1:0]              req_node_id,
   input  logic [NODE_ID_BITS-1:0]              req_parent_node,
   input  logic [bmhq_pkg::COST_BITS-1:0]       req_edge_cost,
   input  logic [KEY_BITS-1:0]                  req_priority_key,
   output logic [1:0]                           rsp_status,
   output logic [NODE_ID_BITS-1:0]              rsp_out_node,
   output logic [NODE_ID_BITS-1:0]              rsp_out_parent,
   output logic [bmhq_pkg::COST_BITS-1:0]       rsp_out_cost,
   output logic [KEY_BITS-1:0]                  rsp_out_key,
   output logic [$clog2(CAPACITY+1)-1:0]        rsp_occupancy
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CB = bmhq_pkg::COST_BITS;
   localparam int PW = 2 * NODE_ID_BITS + CB;
   localparam int EW = KEY_BITS + PW;

   logic [1:0]              cmd_ff;
   logic [EW-1:0]           new_ff;
   logic [EW-1:0]           pop_ff;
   logic [EW-1:0]           item_ff;
   logic [EW-1:0]           cand_ff;
   logic                    cand_item_ff;
   logic [IW-1:0]           cand_idx_ff;
   logic [IW-1:0]           idx_ff;
   logic [CW-1:0]           count_ff;
   logic [1:0]              rsp_status_ff;
   logic [EW-1:0]           rsp_entry_ff;
   logic [CW-1:0]           rsp_occupancy_ff;

   logic                    wr_en;
   logic [IW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data;
   logic [IW-1:0]           rd_addr;
   logic [EW-1:0]           rd_data;

   logic [IW-1:0]           parent_idx;
   logic [IW+1:0]           left_idx;
   logic [IW+1:0]           right_idx;
   logic [IW:0]             next_idx;
   logic [IW+1:0]           count_wide;

   assign parent_idx = (idx_ff - IW'(1)) >> 1;
   assign left_idx   = {1'b0, idx_ff, 1'b1};
   assign right_idx  = left_idx + (IW + 2)'(1);
   assign next_idx   = {1'b0, idx_ff} + (IW + 1)'(1);
   assign count_wide = (IW + 2)'(count_ff);

   bmhq_ram #(
      .WIDTH (EW),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = item_ff;
      rd_addr = '0;
      case (cmd.op)
         bmhq_pkg::OP_UP_READ: begin
            rd_addr = parent_idx;
         end
         bmhq_pkg::OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         bmhq_pkg::OP_PLACE: begin
            wr_en = 1'b1;
         end
         bmhq_pkg::OP_POP_ROOT: begin
            rd_addr = IW'(count_ff - CW'(1));
         end
         bmhq_pkg::OP_DN_READ: begin
            rd_addr = left_idx[IW-1:0];
         end
         bmhq_pkg::OP_DN_LEFT: begin
            rd_addr = right_idx[IW-1:0];
         end
         bmhq_pkg::OP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = cand_ff;
         end
         bmhq_pkg::OP_SCAN_NEXT: begin
            rd_addr = next_idx[IW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         case (cmd.op)
            bmhq_pkg::OP_INS_START: count_ff <= count_ff + CW'(1);
            bmhq_pkg::OP_POP_ROOT:  count_ff <= count_ff - CW'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         bmhq_pkg::OP_LOAD: begin
            cmd_ff <= req_cmd;
            new_ff <= {req_priority_key, req_edge_cost, req_parent_node, req_node_id};
            pop_ff <= '0;
         end
         bmhq_pkg::OP_INS_START: begin
            idx_ff  <= IW'(count_ff);
            item_ff <= new_ff;
         end
         bmhq_pkg::OP_SCAN_START: begin
            idx_ff <= '0;
         end
         bmhq_pkg::OP_UP_MOVE: begin
            idx_ff <= parent_idx;
         end
         bmhq_pkg::OP_POP_ROOT: begin
            pop_ff <= rd_data;
         end
         bmhq_pkg::OP_POP_LAST: begin
            item_ff <= rd_data;
            idx_ff  <= '0;
         end
         bmhq_pkg::OP_DN_LEFT: begin
            cand_idx_ff <= left_idx[IW-1:0];
            if (rd_data[EW-1 -: KEY_BITS] < item_ff[EW-1 -: KEY_BITS]) begin
               cand_ff      <= rd_data;
               cand_item_ff <= 1'b0;
            end else begin
               cand_ff      <= item_ff;
               cand_item_ff <= 1'b1;
            end
         end
         bmhq_pkg::OP_DN_RIGHT: begin
            if (rd_data[EW-1 -: KEY_BITS] < cand_ff[EW-1 -: KEY_BITS]) begin
               cand_ff      <= rd_data;
               cand_item_ff <= 1'b0;
               cand_idx_ff  <= right_idx[IW-1:0];
            end
         end
         bmhq_pkg::OP_DN_MOVE: begin
            idx_ff <= cand_idx_ff;
         end
         bmhq_pkg::OP_SCAN_NEXT: begin
            idx_ff <= next_idx[IW-1:0];
         end
         bmhq_pkg::OP_SCAN_HIT: begin
            item_ff <= new_ff;
         end
         bmhq_pkg::OP_RESPOND: begin
            rsp_status_ff    <= cmd.status;
            rsp_entry_ff     <= pop_ff;
            rsp_occupancy_ff <= count_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      stat.cmd       = cmd_ff;
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.idx_zero  = (idx_ff == '0);
      stat.up_swap   = (rd_data[EW-1 -: KEY_BITS] > item_ff[EW-1 -: KEY_BITS]);
      stat.dn_leaf   = (left_idx >= count_wide);
      stat.right_in  = (right_idx < count_wide);
      stat.cand_item = cand_item_ff;
      stat.id_match  = (rd_data[NODE_ID_BITS-1:0] == new_ff[NODE_ID_BITS-1:0]);
      stat.scan_end  = ((IW + 2)'(next_idx) >= count_wide);
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_out_node   = rsp_entry_ff[NODE_ID_BITS-1:0];
   assign rsp_out_parent = rsp_entry_ff[2*NODE_ID_BITS-1:NODE_ID_BITS];
   assign rsp_out_cost   = rsp_entry_ff[PW-1:2*NODE_ID_BITS];
   assign rsp_out_key    = rsp_entry_ff[EW-1 -: KEY_BITS];
   assign rsp_occupancy  = rsp_occupancy_ff;

endmodule

[sv/bmhq_ctrl.sv]
// Heap controller: state machine that sequences insert, pop and decrease
// through datapath operations and owns the handshake. Depends on bmhq_pkg.
module bmhq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  bmhq_pkg::dp_stat_type stat,
   output bmhq_pkg::dp_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DISPATCH  = 4'd1;
   localparam logic [3:0] S_UP_CHECK  = 4'd2;
   localparam logic [3:0] S_UP_CMP    = 4'd3;
   localparam logic [3:0] S_POP_ROOT  = 4'd4;
   localparam logic [3:0] S_POP_LAST  = 4'd5;
   localparam logic [3:0] S_DN_CHECK  = 4'd6;
   localparam logic [3:0] S_DN_LEFT   = 4'd7;
   localparam logic [3:0] S_DN_RIGHT  = 4'd8;
   localparam logic [3:0] S_DN_DECIDE = 4'd9;
   localparam logic [3:0] S_SCAN      = 4'd10;
   localparam logic [3:0] S_FINISH    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = bmhq_pkg::OP_IDLE;
      cmd.status   = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = bmhq_pkg::OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = bmhq_pkg::ST_OK;
            state_in  = S_FINISH;
            case (stat.cmd)
               bmhq_pkg::CMD_INSERT: begin
                  if (stat.full) begin
                     status_in = bmhq_pkg::ST_FULL;
                  end else begin
                     cmd.op   = bmhq_pkg::OP_INS_START;
                     state_in = S_UP_CHECK;
                  end
               end
               bmhq_pkg::CMD_POP: begin
                  if (stat.empty) begin
                     status_in = bmhq_pkg::ST_EMPTY;
                  end else begin
                     cmd.op   = bmhq_pkg::OP_POP_START;
                     state_in = S_POP_ROOT;
                  end
               end
               bmhq_pkg::CMD_DECREASE: begin
                  if (stat.empty) begin
                     status_in = bmhq_pkg::ST_NOT_FOUND;
                  end else begin
                     cmd.op   = bmhq_pkg::OP_SCAN_START;
                     state_in = S_SCAN;
                  end
               end
               default: begin
               end
            endcase
         end
         S_UP_CHECK: begin
            if (stat.idx_zero) begin
               cmd.op   = bmhq_pkg::OP_PLACE;
               state_in = S_FINISH;
            end else begin
               cmd.op   = bmhq_pkg::OP_UP_READ;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_swap) begin
               cmd.op   = bmhq_pkg::OP_UP_MOVE;
               state_in = S_UP_CHECK;
            end else begin
               cmd.op   = bmhq_pkg::OP_PLACE;
               state_in = S_FINISH;
            end
         end
         S_POP_ROOT: begin
            cmd.op   = bmhq_pkg::OP_POP_ROOT;
            state_in = S_POP_LAST;
         end
         S_POP_LAST: begin
            // Popping the only entry leaves nothing to sift.
            cmd.op   = bmhq_pkg::OP_POP_LAST;
            state_in = stat.empty ? S_FINISH : S_DN_CHECK;
         end
         S_DN_CHECK: begin
            if (stat.dn_leaf) begin
               cmd.op   = bmhq_pkg::OP_PLACE;
               state_in = S_FINISH;
            end else begin
               cmd.op   = bmhq_pkg::OP_DN_READ;
               state_in = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            cmd.op   = bmhq_pkg::OP_DN_LEFT;
            state_in = stat.right_in ? S_DN_RIGHT : S_DN_DECIDE;
         end
         S_DN_RIGHT: begin
            cmd.op   = bmhq_pkg::OP_DN_RIGHT;
            state_in = S_DN_DECIDE;
         end
         S_DN_DECIDE: begin
            if (stat.cand_item) begin
               cmd.op   = bmhq_pkg::OP_PLACE;
               state_in = S_FINISH;
            end else begin
               cmd.op   = bmhq_pkg::OP_DN_MOVE;
               state_in = S_DN_CHECK;
            end
         end
         S_SCAN: begin
            if (stat.id_match) begin
               cmd.op   = bmhq_pkg::OP_SCAN_HIT;
               state_in = S_UP_CHECK;
            end else if (stat.scan_end) begin
               status_in = bmhq_pkg::ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.op = bmhq_pkg::OP_SCAN_NEXT;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op       = bmhq_pkg::OP_RESPOND;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         status_ff    <= bmhq_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/binary_min_heap_queue_unit.sv]
// Binary min-heap priority queue. One request at a time; a new request is taken
// while the previous response still waits. Insert sifts the new entry up level by
// level; pop moves the last entry to the root and sifts it down; decrease scans the
// occupied slots in order and, on a hit, sifts the updated entry up from the hit slot.
// The single RAM read port serializes these steps.
// Reset clears control state and entry count only; data read from unoccupied RAM
// slots is never used.
module binary_min_heap_queue_unit #(
   parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
   parameter int NODE_ID_BITS = bmhq_pkg::NODE_ID_BITS_DEF,
   parameter int KEY_BITS     = bmhq_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic [NODE_ID_BITS-1:0]           req_node_id,
   input  logic [NODE_ID_BITS-1:0]           req_parent_node,
   input  logic [bmhq_pkg::COST_BITS-1:0]    req_edge_cost,
   input  logic [KEY_BITS-1:0]               req_priority_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [NODE_ID_BITS-1:0]           rsp_out_node,
   output logic [NODE_ID_BITS-1:0]           rsp_out_parent,
   output logic [bmhq_pkg::COST_BITS-1:0]    rsp_out_cost,
   output logic [KEY_BITS-1:0]               rsp_out_key,
   output logic [$clog2(CAPACITY+1)-1:0]     rsp_occupancy
);

   bmhq_pkg::dp_cmd_type  dp_cmd;
   bmhq_pkg::dp_stat_type dp_stat;

   bmhq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   bmhq_datapath #(
      .CAPACITY     (CAPACITY),
      .NODE_ID_BITS (NODE_ID_BITS),
      .KEY_BITS     (KEY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .req_cmd          (req_cmd),
      .req_node_id      (req_node_id),
      .req_parent_node  (req_parent_node),
      .req_edge_cost    (req_edge_cost),
      .req_priority_key (req_priority_key),
      .rsp_status       (rsp_status),
      .rsp_out_node     (rsp_out_node),
      .rsp_out_parent   (rsp_out_parent),
      .rsp_out_cost     (rsp_out_cost),
      .rsp_out_key      (rsp_out_key),
      .rsp_occupancy    (rsp_occupancy)
   );

`ifndef NO_ASSERTIONS
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= ($clog2(CAPACITY+1))'(CAPACITY)))
      else $error("occupancy above capacity");

   a_empty_means_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::ST_EMPTY) |-> (rsp_occupancy == '0))
      else $error("empty status with entries held");

   a_full_means_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == bmhq_pkg::ST_FULL)
      |-> (rsp_occupancy == ($clog2(CAPACITY+1))'(CAPACITY)))
      else $error("full status below capacity");

   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != bmhq_pkg::ST_OK)
      |-> (rsp_out_node == '0 && rsp_out_key == '0 && rsp_out_cost == '0))
      else $error("error response carries an entry");
`endif

endmodule

[bench/binary_min_heap_queue_unit_check.sv]
// Response checker for the binary min-heap queue: a shadow heap predicts each
// response from the accepted requests and compares it field by field.
// Depends on bmhq_pkg for command and status codes.
module binary_min_heap_queue_unit_check #(
   parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
   parameter int NODE_ID_BITS = bmhq_pkg::NODE_ID_BITS_DEF,
   parameter int KEY_BITS     = bmhq_pkg::KEY_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [NODE_ID_BITS-1:0]             req_node_id,
   input  logic [NODE_ID_BITS-1:0]             req_parent_node,
   input  logic [bmhq_pkg::COST_BITS-1:0]      req_edge_cost,
   input  logic [KEY_BITS-1:0]                 req_priority_key,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_status,
   input  logic [NODE_ID_BITS-1:0]             rsp_out_node,
   input  logic [NODE_ID_BITS-1:0]             rsp_out_parent,
   input  logic [bmhq_pkg::COST_BITS-1:0]      rsp_out_cost,
   input  logic [KEY_BITS-1:0]                 rsp_out_key,
   input  logic [$clog2(CAPACITY+1)-1:0]       rsp_occupancy,
   output int                                  errors,
   output int                                  pending
);

   localparam int OCC_BITS = $clog2(CAPACITY+1);
   localparam int CB       = bmhq_pkg::COST_BITS;

   typedef struct packed {
      logic [1:0]              status;
      logic [NODE_ID_BITS-1:0] node;
      logic [NODE_ID_BITS-1:0] parent;
      logic [CB-1:0]           cost;
      logic [KEY_BITS-1:0]     key;
      logic [OCC_BITS-1:0]     occ;
   } heap_result_type;

   logic [KEY_BITS-1:0]     key_mem[CAPACITY];
   logic [NODE_ID_BITS-1:0] node_mem[CAPACITY];
   logic [NODE_ID_BITS-1:0] parent_mem[CAPACITY];
   logic [CB-1:0]           cost_mem[CAPACITY];
   int                      fill_count;
   heap_result_type         awaited_results[$];

   initial errors = 0;
   assign pending = awaited_results.size();

   function automatic void exchange_slots(int a, int b);
      logic [KEY_BITS-1:0]     k;
      logic [NODE_ID_BITS-1:0] n;
      logic [NODE_ID_BITS-1:0] p;
      logic [CB-1:0]           c;
      k = key_mem[a];    key_mem[a] = key_mem[b];       key_mem[b] = k;
      n = node_mem[a];   node_mem[a] = node_mem[b];     node_mem[b] = n;
      p = parent_mem[a]; parent_mem[a] = parent_mem[b]; parent_mem[b] = p;
      c = cost_mem[a];   cost_mem[a] = cost_mem[b];     cost_mem[b] = c;
   endfunction

   // An entry climbs only past a strictly larger parent.
   function automatic void climb_from(int slot);
      int i;
      int up;
      i = slot;
      while (i > 0) begin
         up = (i - 1) / 2;
         if (key_mem[up] > key_mem[i]) begin
            exchange_slots(up, i);
            i = up;
         end else begin
            break;
         end
      end
   endfunction

   // Ties keep the entry in place, then favor the left child.
   function automatic void settle_root();
      int i;
      int best;
      i = 0;
      while (i < fill_count) begin
         best = i;
         if (2*i+1 < fill_count && key_mem[2*i+1] < key_mem[best]) best = 2*i+1;
         if (2*i+2 < fill_count && key_mem[2*i+2] < key_mem[best]) best = 2*i+2;
         if (best == i) break;
         exchange_slots(best, i);
         i = best;
      end
   endfunction

   function automatic heap_result_type apply_request(logic [1:0] cmd,
         logic [NODE_ID_BITS-1:0] node, logic [NODE_ID_BITS-1:0] parent,
         logic [CB-1:0] cost, logic [KEY_BITS-1:0] key);
      heap_result_type r;
      r = '0;
      r.status = bmhq_pkg::ST_OK;
      case (cmd)
         bmhq_pkg::CMD_INSERT: begin
            if (fill_count >= CAPACITY) begin
               r.status = bmhq_pkg::ST_FULL;
            end else begin
               key_mem[fill_count] = key;
               node_mem[fill_count] = node;
               parent_mem[fill_count] = parent;
               cost_mem[fill_count] = cost;
               fill_count++;
               climb_from(fill_count - 1);
            end
         end
         bmhq_pkg::CMD_POP: begin
            if (fill_count == 0) begin
               r.status = bmhq_pkg::ST_EMPTY;
            end else begin
               r.node = node_mem[0];
               r.parent = parent_mem[0];
               r.cost = cost_mem[0];
               r.key = key_mem[0];
               fill_count--;
               key_mem[0] = key_mem[fill_count];
               node_mem[0] = node_mem[fill_count];
               parent_mem[0] = parent_mem[fill_count];
               cost_mem[0] = cost_mem[fill_count];
               settle_root();
            end
         end
         bmhq_pkg::CMD_DECREASE: begin
            r.status = bmhq_pkg::ST_NOT_FOUND;
            for (int i = 0; i < fill_count; i++) begin
               if (node_mem[i] == node) begin
                  key_mem[i] = key;
                  parent_mem[i] = parent;
                  cost_mem[i] = cost;
                  climb_from(i);
                  r.status = bmhq_pkg::ST_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      r.occ = OCC_BITS'(fill_count);
      return r;
   endfunction

   always @(posedge clock) begin
      heap_result_type want;
      heap_result_type got;
      if (reset) begin
         fill_count = 0;
         awaited_results.delete();
      end else begin
         // Responses are checked before this edge's request is predicted, so a
         // response is never matched against the prediction of a request taken at this edge.
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_out_node, rsp_out_parent, rsp_out_cost,
                    rsp_out_key, rsp_occupancy};
            if (awaited_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("MISMATCH: response with none outstanding, status %0d",
                           rsp_status);
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.node !== want.node ||
                   got.parent !== want.parent || got.cost !== want.cost ||
                   got.key !== want.key || got.occ !== want.occ) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("MISMATCH: expected status %0d node %0d parent %0d",
                              want.status, want.node, want.parent);
                     $display("   cost %h key %h occupancy %0d",
                              want.cost, want.key, want.occ);
                     $display("   actual status %0d node %0d parent %0d",
                              got.status, got.node, got.parent);
                     $display("   cost %h key %h occupancy %0d",
                              got.cost, got.key, got.occ);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(apply_request(req_cmd, req_node_id,
               req_parent_node, req_edge_cost, req_priority_key));
      end
   end

endmodule

[bench/binary_min_heap_queue_unit_test.sv]
// Stimulus and verdict for the binary min-heap queue: directed corner
// requests, random traffic, and a drain past empty. Depends on bmhq_pkg,
// the queue unit and binary_min_heap_queue_unit_check.
module binary_min_heap_queue_unit_test;

   localparam int CAP = bmhq_pkg::CAPACITY_DEF;
   localparam int NB  = bmhq_pkg::NODE_ID_BITS_DEF;
   localparam int KB  = bmhq_pkg::KEY_BITS_DEF;
   localparam int CB  = bmhq_pkg::COST_BITS;
   localparam int OB  = $clog2(CAP+1);
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = bmhq_pkg::CMD_INSERT;
   logic [NB-1:0] req_node_id = '0;
   logic [NB-1:0] req_parent_node = '0;
   logic [CB-1:0] req_edge_cost = '0;
   logic [KB-1:0] req_priority_key = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic [NB-1:0] rsp_out_node;
   logic [NB-1:0] rsp_out_parent;
   logic [CB-1:0] rsp_out_cost;
   logic [KB-1:0] rsp_out_key;
   logic [OB-1:0] rsp_occupancy;

   int errors;
   int pending;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles = 0;
   int occ = 0;
   int inserts = 0, pops = 0, decreases = 0, unused = 0;

   binary_min_heap_queue_unit uut (.*);
   binary_min_heap_queue_unit_check checker_i (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Leaves req_valid high on return; the next call updates or lowers it, or drain_wait lowers it.
   task automatic send(logic [1:0] cmd, logic [NB-1:0] node, logic [NB-1:0] parent,
                       logic [CB-1:0] cost, logic [KB-1:0] key);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_node_id <= node;
      req_parent_node <= parent;
      req_edge_cost <= cost;
      req_priority_key <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (cmd)
         bmhq_pkg::CMD_INSERT: begin
            inserts++;
            if (occ < CAP) occ++;
         end
         bmhq_pkg::CMD_POP: begin
            pops++;
            if (occ > 0) occ--;
         end
         bmhq_pkg::CMD_DECREASE: decreases++;
         default: unused++;
      endcase
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_request();
      int pick;
      logic [1:0] cmd;
      logic [NB-1:0] node;
      logic [KB-1:0] key;
      pick = $urandom_range(99);
      if (pick < 3)
         cmd = bmhq_pkg::CMD_RESERVED;
      else if (occ < 6)
         cmd = (pick < 70) ? bmhq_pkg::CMD_INSERT :
               (pick < 85) ? bmhq_pkg::CMD_POP : bmhq_pkg::CMD_DECREASE;
      else if (occ > 48)
         cmd = (pick < 25) ? bmhq_pkg::CMD_INSERT :
               (pick < 75) ? bmhq_pkg::CMD_POP : bmhq_pkg::CMD_DECREASE;
      else
         cmd = (pick < 45) ? bmhq_pkg::CMD_INSERT :
               (pick < 75) ? bmhq_pkg::CMD_POP : bmhq_pkg::CMD_DECREASE;
      // A small id pool makes duplicates and decrease hits common.
      node = ($urandom_range(9) < 7) ? NB'($urandom_range(0, 31)) : NB'($urandom);
      key = ($urandom_range(9) < 4) ? KB'($urandom_range(0, 15)) : KB'($urandom);
      send(cmd, node, NB'($urandom), $urandom, key);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners.
      send(bmhq_pkg::CMD_POP, '0, '0, '0, '0);
      send(bmhq_pkg::CMD_DECREASE, 11'd5, '0, '0, '0);
      send(bmhq_pkg::CMD_RESERVED, '1, '1, '1, '1);
      send(bmhq_pkg::CMD_INSERT, '1, '1, '1, '1);
      send(bmhq_pkg::CMD_INSERT, '0, '0, '0, '0);
      send(bmhq_pkg::CMD_INSERT, 11'd7, 11'd1, 32'h100, 32'h500);
      send(bmhq_pkg::CMD_INSERT, 11'd7, 11'd2, 32'h200, 32'h500);
      send(bmhq_pkg::CMD_INSERT, 11'd9, 11'd3, 32'h300, 32'h500);
      send(bmhq_pkg::CMD_DECREASE, 11'd7, 11'd4, 32'h400, 32'h1);
      send(bmhq_pkg::CMD_DECREASE, 11'd9, 11'd5, 32'h500, 32'hFFFF_FFF0);
      send(bmhq_pkg::CMD_DECREASE, 11'd1234, '0, '0, '0);
      send(bmhq_pkg::CMD_INSERT, 11'h555, 11'h2AA, 32'hAAAA_5555, 32'h5555_AAAA);
      send(bmhq_pkg::CMD_INSERT, 11'h2AA, 11'h555, 32'h5555_AAAA, 32'h0000_0001);
      repeat (8) send(bmhq_pkg::CMD_POP, '0, '0, '0, '0);

      // Random traffic in three idling regimes.
      for (int i = 0; i < 900; i++) begin
         if (i == 0) begin
            send_idle_pct = 24; recv_idle_pct = 61;
         end else if (i == 300) begin
            send_idle_pct = 61; recv_idle_pct = 24;
         end else if (i == 600) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         if (i == 450) drain_wait();
         random_request();
      end

      // Drain the heap, then pop once more past empty.
      while (occ > 0) send(bmhq_pkg::CMD_POP, '0, '0, '0, '0);
      send(bmhq_pkg::CMD_POP, '0, '0, '0, '0);

      drain_wait();
      recv_idle_pct = 0;
      repeat (100) @(posedge clock);
      $display("Covered %0d inserts, %0d pops, %0d decreases, %0d unused commands,",
               inserts, pops, decreases, unused);
      $display("including an empty heap, duplicate ids and three idling regimes.");
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("Mismatches %0d, responses missing %0d", errors, pending);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[binary_min_heap_queue_unit.f]
sv/bmhq_pkg.sv
sv/bmhq_ram.sv
sv/bmhq_datapath.sv
sv/bmhq_ctrl.sv
sv/binary_min_heap_queue_unit.sv
bench/binary_min_heap_queue_unit_check.sv
bench/binary_min_heap_queue_unit_test.sv
